>>> rtl/core/sdf_pkg.sv
// Package for the signed radix digit formatter.
// Holds sizes, symbol and register index codes, the controller state type and
// the alphabet symbol lookup. No dependencies.
package sdf_pkg;

   localparam int VALUE_BITS = 32;
   localparam int MAX_RADIX = 16;

   localparam int SYM_W = 8;
   localparam int NUM_SYMBOLS = 16;
   localparam int SYM_IDX_W = 4;
   localparam int LEN_W = 5;
   localparam int WORD_W = 64;
   localparam int CSR_IDX_W = 2;

   localparam int DIGIT_W = $clog2(MAX_RADIX);
   localparam int STEP_BITS = 4;
   localparam int STEPS_PER_DIGIT = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int MAG_W = STEPS_PER_DIGIT * STEP_BITS;
   localparam int STEP_CNT_W = (STEPS_PER_DIGIT > 1) ? $clog2(STEPS_PER_DIGIT) : 1;
   localparam int MAX_DIGITS = VALUE_BITS;
   localparam int DEPTH_W = $clog2(MAX_DIGITS + 1);

   localparam logic [SYM_W-1:0] SYM_PLUS = 8'h2B;
   localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOLS_LOW = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOLS_HIGH = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } sdf_state_type;

   function automatic logic [SYM_W-1:0] symbol_at(input logic [WORD_W-1:0] sym_lo,
                                                  input logic [WORD_W-1:0] sym_hi,
                                                  input logic [SYM_IDX_W-1:0] idx);
      logic [WORD_W-1:0] word;
      word = idx[SYM_IDX_W-1] ? sym_hi : sym_lo;
      return word[SYM_W * idx[SYM_IDX_W-2:0] +: SYM_W];
   endfunction

endpackage

>>> rtl/core/sdf_channels.sv
// Valid/ready channel interfaces of the signed radix digit formatter.
// Request, response and register write channels; depends on sdf_pkg.
interface sdf_req_if import sdf_pkg::*;;
   logic valid;
   logic ready;
   logic signed [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface sdf_rsp_if import sdf_pkg::*;;
   logic valid;
   logic ready;
   logic [SYM_W-1:0] character;
   logic last;

   modport source (output valid, output character, output last, input ready);
   modport sink (input valid, input character, input last, output ready);
endinterface

interface sdf_csr_if import sdf_pkg::*;;
   logic valid;
   logic ready;
   logic [CSR_IDX_W-1:0] index;
   logic [WORD_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/signed_radix_digit_formatter.sv
// A value is divided digit by digit in the remainder unit, which retires 4
// quotient bits per cycle; then its characters leave one per cycle while the
// response channel is not stalled. A new value is accepted only once the last
// character of the previous one has been loaded for output.
// Reset clears the control state, the output valid flag and the configuration
// registers; with a zero alphabet length every transaction produces no
// characters until the alphabet is written.
module signed_radix_digit_formatter import sdf_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   sdf_req_if.sink   req_chan,
   sdf_rsp_if.source rsp_chan,
   sdf_csr_if.sink   csr_chan
);

   logic [LEN_W-1:0]  base_length_ff;
   logic [WORD_W-1:0] symbols_low_ff;
   logic [WORD_W-1:0] symbols_high_ff;
   logic              alpha_ok;

   sdf_state_type state_ff, state_in;

   logic [MAG_W-1:0]      mag_ff, mag_in;
   logic [DIGIT_W-1:0]    rem_ff, rem_in;
   logic [STEP_CNT_W-1:0] step_cnt_ff, step_cnt_in;
   logic [DEPTH_W-1:0]    depth_ff, depth_in;
   logic                  neg_pending_ff, neg_pending_in;
   logic [DIGIT_W-1:0]    stack_ff [MAX_DIGITS];
   logic [DIGIT_W-1:0]    stack_in [MAX_DIGITS];

   logic              rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0]  rsp_char_ff, rsp_char_in;
   logic              rsp_last_ff, rsp_last_in;

   logic                  req_accept;
   logic                  last_step;
   logic                  push_digit;
   logic                  out_load;
   logic                  pop_digit;
   logic [MAG_W-1:0]      mag_next;
   logic [DIGIT_W-1:0]    rem_next;
   logic [DIGIT_W:0]      radix;
   logic [VALUE_BITS-1:0] value_raw;
   logic [VALUE_BITS-1:0] value_abs;
   logic                  value_neg;

   sdf_alpha_check u_alpha_check (
      .base_length  (base_length_ff),
      .symbols_low  (symbols_low_ff),
      .symbols_high (symbols_high_ff),
      .alpha_ok     (alpha_ok)
   );

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_length_ff <= '0;
         symbols_low_ff <= '0;
         symbols_high_ff <= '0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_BASE_LENGTH: begin
               base_length_ff <= csr_chan.data[LEN_W-1:0];
            end
            CSR_SYMBOLS_LOW: begin
               symbols_low_ff <= csr_chan.data;
            end
            CSR_SYMBOLS_HIGH: begin
               symbols_high_ff <= csr_chan.data;
            end
            default: begin
            end
         endcase
      end
   end

   assign radix = base_length_ff[DIGIT_W:0];
   assign value_raw = req_chan.value;
   assign value_neg = value_raw[VALUE_BITS-1];
   assign value_abs = value_neg ? VALUE_BITS'(~value_raw + 1'b1) : value_raw;

   // Restoring division step: STEP_BITS quotient bits per cycle.
   always_comb begin
      logic [DIGIT_W:0]     part;
      logic [DIGIT_W-1:0]   rem;
      logic [STEP_BITS-1:0] quo;
      rem = rem_ff;
      quo = '0;
      for (int k = 0; k < STEP_BITS; k++) begin
         part = {rem, mag_ff[MAG_W-1-k]};
         if (part >= radix) begin
            rem = DIGIT_W'(part - radix);
            quo[STEP_BITS-1-k] = 1'b1;
         end else begin
            rem = part[DIGIT_W-1:0];
         end
      end
      rem_next = rem;
      mag_next = {mag_ff[MAG_W-STEP_BITS-1:0], quo};
   end

   assign req_accept = req_chan.valid && req_chan.ready;
   assign last_step = (step_cnt_ff == STEP_CNT_W'(STEPS_PER_DIGIT - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && alpha_ok) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (last_step && mag_next == '0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_load && !neg_pending_ff && depth_ff == DEPTH_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_chan.ready = (state_ff == ST_IDLE);
      push_digit = (state_ff == ST_DIVIDE) && last_step;
      out_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_chan.ready);
      pop_digit = out_load && !neg_pending_ff;
   end

   always_comb begin
      mag_in = mag_ff;
      rem_in = rem_ff;
      step_cnt_in = step_cnt_ff;
      depth_in = depth_ff;
      neg_pending_in = neg_pending_ff;
      stack_in = stack_ff;
      if (req_accept) begin
         mag_in = MAG_W'(value_abs);
         rem_in = '0;
         step_cnt_in = '0;
         depth_in = '0;
         neg_pending_in = value_neg;
      end
      if (state_ff == ST_DIVIDE) begin
         mag_in = mag_next;
         rem_in = last_step ? '0 : rem_next;
         step_cnt_in = last_step ? '0 : step_cnt_ff + 1'b1;
      end
      if (push_digit) begin
         depth_in = depth_ff + 1'b1;
         stack_in[0] = rem_next;
         for (int i = 1; i < MAX_DIGITS; i++) begin
            stack_in[i] = stack_ff[i-1];
         end
      end
      if (out_load) begin
         neg_pending_in = 1'b0;
      end
      if (pop_digit) begin
         depth_in = depth_ff - 1'b1;
         for (int i = 0; i < MAX_DIGITS - 1; i++) begin
            stack_in[i] = stack_ff[i+1];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         if (neg_pending_ff) begin
            rsp_char_in = SYM_MINUS;
            rsp_last_in = 1'b0;
         end else begin
            rsp_char_in = symbol_at(symbols_low_ff, symbols_high_ff,
                                    SYM_IDX_W'(stack_ff[0]));
            rsp_last_in = (depth_ff == DEPTH_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         depth_ff <= '0;
         neg_pending_ff <= 1'b0;
         step_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         depth_ff <= depth_in;
         neg_pending_ff <= neg_pending_in;
         step_cnt_ff <= step_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      stack_ff <= stack_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.character = rsp_char_ff;
   assign rsp_chan.last = rsp_last_ff;

`ifndef ASSERT_OFF
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(MAX_DIGITS))
      else $error("digit stack depth exceeds the digit limit");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> (depth_ff != '0 || neg_pending_ff))
      else $error("emit state entered with nothing to send");

   a_bad_alphabet_silent: assert property (@(posedge clock) disable iff (reset)
      req_accept && !alpha_ok |=> state_ff == ST_IDLE)
      else $error("transaction with an unusable alphabet started work");
`endif

endmodule

>>> rtl/core/sdf_alpha_check.sv
// Alphabet validity check of the signed radix digit formatter.
// Flags a usable alphabet from the length and symbol registers; uses sdf_pkg.
module sdf_alpha_check import sdf_pkg::*; (
   input  logic [LEN_W-1:0]  base_length,
   input  logic [WORD_W-1:0] symbols_low,
   input  logic [WORD_W-1:0] symbols_high,
   output logic              alpha_ok
);

   logic [SYM_W-1:0] sym [NUM_SYMBOLS];
   logic bad;

   always_comb begin
      for (int i = 0; i < NUM_SYMBOLS; i++) begin
         sym[i] = symbol_at(symbols_low, symbols_high, SYM_IDX_W'(i));
      end
   end

   always_comb begin
      bad = (base_length < LEN_W'(2)) || (base_length > LEN_W'(MAX_RADIX));
      for (int i = 0; i < NUM_SYMBOLS; i++) begin
         if (base_length > LEN_W'(i)) begin
            if (sym[i] == SYM_PLUS || sym[i] == SYM_MINUS) begin
               bad = 1'b1;
            end
            for (int j = 0; j < i; j++) begin
               if (sym[j] == sym[i]) begin
                  bad = 1'b1;
               end
            end
         end
      end
      alpha_ok = !bad;
   end

endmodule
